// ===== hw/rtl/gbrc_pkg.sv =====
// shared constants, types and lookup functions for the gamepad remap and chord block
`timescale 1ns / 1ps

package gbrc_pkg;

    localparam int BUTTON_COUNT = 21;
    localparam int MAX_CHORDS   = 8;
    localparam int QUEUE_DEPTH  = 16;

    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CHORD_CNT_W = 4;
    localparam int TGT_W       = 5;
    localparam int BIND_W      = 16;
    localparam int LOW_SOURCES = 12;

    // button positions
    localparam int IDX_L2    = 0;
    localparam int IDX_UP    = 3;
    localparam int IDX_LEFT  = 4;
    localparam int IDX_DOWN  = 5;
    localparam int IDX_RIGHT = 6;
    localparam int IDX_R2    = 8;
    localparam int IDX_LFN   = 18;
    localparam int IDX_RFN   = 19;
    localparam int IDX_PS    = 20;

    localparam logic [7:0] MUTE_MASK     = 8'h04;
    localparam logic [7:0] SYS_KEEP_MASK = 8'h0e;
    localparam logic [7:0] HAT_MASK      = 8'h0f;
    localparam logic [7:0] TRIG_FULL     = 8'hff;
    localparam logic [3:0] HAT_NEUTRAL   = 4'd8;

    // word kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    // chord starter codes
    localparam logic [2:0] STARTER_PS   = 3'd1;
    localparam logic [2:0] STARTER_LFN  = 3'd2;
    localparam logic [2:0] STARTER_RFN  = 3'd3;
    localparam logic [2:0] STARTER_MUTE = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_REMAP_ENABLE  = 3'd0;
    localparam logic [2:0] CFG_TARGETS_LOW   = 3'd1;
    localparam logic [2:0] CFG_TARGETS_HIGH  = 3'd2;
    localparam logic [2:0] CFG_BINDINGS_LOW  = 3'd3;
    localparam logic [2:0] CFG_BINDINGS_HIGH = 3'd4;
    localparam logic [2:0] CFG_CHORD_COUNT   = 3'd5;

    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_FACE,
        SEL_SHOULDER,
        SEL_SYSTEM
    } btn_byte_t;

    // which report byte and bit carries each button; hat buttons have none
    localparam btn_byte_t BTN_SEL [BUTTON_COUNT] = '{
        SEL_SHOULDER, SEL_SHOULDER, SEL_SHOULDER, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE,
        SEL_SHOULDER, SEL_SHOULDER, SEL_SHOULDER, SEL_SHOULDER, SEL_FACE, SEL_FACE,
        SEL_FACE, SEL_FACE, SEL_SHOULDER, SEL_SYSTEM, SEL_SYSTEM, SEL_SYSTEM,
        SEL_SYSTEM, SEL_SYSTEM
    };

    localparam logic [7:0] BTN_MASK [BUTTON_COUNT] = '{
        8'h04, 8'h01, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h40, 8'h08, 8'h02, 8'h20, 8'h80, 8'h40,
        8'h20, 8'h10, 8'h80, 8'h40, 8'h80, 8'h10,
        8'h20, 8'h01
    };

    // hat code to direction set: bit 0 up, 1 right, 2 down, 3 left
    function automatic logic [3:0] hat_to_dirs(input logic [3:0] hat);
        logic [3:0] d;
        case (hat)
            4'd0:    d = 4'h1;
            4'd1:    d = 4'h3;
            4'd2:    d = 4'h2;
            4'd3:    d = 4'h6;
            4'd4:    d = 4'h4;
            4'd5:    d = 4'hc;
            4'd6:    d = 4'h8;
            4'd7:    d = 4'h9;
            default: d = 4'h0;
        endcase
        return d;
    endfunction

    // direction set back to hat code, neutral when no code matches
    function automatic logic [3:0] dirs_to_hat(input logic [3:0] dirs);
        logic [3:0] h;
        case (dirs)
            4'h1:    h = 4'd0;
            4'h3:    h = 4'd1;
            4'h2:    h = 4'd2;
            4'h6:    h = 4'd3;
            4'h4:    h = 4'd4;
            4'hc:    h = 4'd5;
            4'h8:    h = 4'd6;
            4'h9:    h = 4'd7;
            default: h = HAT_NEUTRAL;
        endcase
        return h;
    endfunction

endpackage

// ===== hw/rtl/gamepad_button_remap_chord.sv =====
// top level: gamepad button decode, chord events, remap and repack in one registered pass
// m_valid rises in the cycle after a word is accepted on the s_ side
// throughput: one word per cycle unless a low m_ready holds a full result register; the chord
// scan and the remap are unrolled logic between the input handshake and the result register
// reset (aresetn low, synchronous): configuration registers, m_valid, button history and queue
// pointers cleared; event queue entries hold no reset value and are only read once written
`timescale 1ns / 1ps

module gamepad_button_remap_chord (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_dpad_face_byte,
    input  logic [7:0]  s_shoulder_byte,
    input  logic [7:0]  s_system_byte,
    input  logic [7:0]  s_left_trigger_level,
    input  logic [7:0]  s_right_trigger_level,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_dpad_face_byte,
    output logic [7:0]  m_out_shoulder_byte,
    output logic [7:0]  m_out_system_byte,
    output logic [7:0]  m_out_left_trigger,
    output logic [7:0]  m_out_right_trigger,
    output logic [7:0]  m_event_code
);

    localparam int NB  = gbrc_pkg::BUTTON_COUNT;
    localparam int NC  = gbrc_pkg::MAX_CHORDS;
    localparam int QD  = gbrc_pkg::QUEUE_DEPTH;
    localparam int QIW = gbrc_pkg::QIDX_W;
    localparam int QCW = gbrc_pkg::QCNT_W;
    localparam int TW  = gbrc_pkg::TGT_W;
    localparam int BW  = gbrc_pkg::BIND_W;

    // configuration registers
    logic                                remap_enable_reg;
    logic [59:0]                         targets_low_reg;
    logic [44:0]                         targets_high_reg;
    logic [63:0]                         bindings_low_reg;
    logic [63:0]                         bindings_high_reg;
    logic [gbrc_pkg::CHORD_CNT_W-1:0]    chord_count_reg;

    // button history
    logic [NB-1:0] prev_buttons_reg;
    logic [NB-1:0] consumed_reg;

    // event queue: entry storage, read pointer and fill count
    logic [7:0]     queue_mem [QD];
    logic [QIW-1:0] head_reg;
    logic [QCW-1:0] count_reg;

    // result register
    logic       m_valid_reg;
    logic [7:0] o_face_reg;
    logic [7:0] o_shoulder_reg;
    logic [7:0] o_system_reg;
    logic [7:0] o_left_reg;
    logic [7:0] o_right_reg;
    logic [7:0] o_event_reg;

    logic in_fire;
    logic cfg_fire;
    logic is_pop;
    logic bypass;

    // decode and chord scan results
    logic [NB-1:0]  btn_raw;
    logic [NB-1:0]  btn_vis;
    logic [NB-1:0]  btn_out;
    logic [NB-1:0]  consumed_next;
    logic [QCW-1:0] count_after_push;
    logic           wr_en   [NC];
    logic [QIW-1:0] wr_addr [NC];
    logic [7:0]     wr_data [NC];
    logic [TW-1:0]  tgt     [NB];
    logic [7:0]     left_next;
    logic [7:0]     right_next;
    logic [7:0]     face_next;
    logic [7:0]     shoulder_next;
    logic [7:0]     system_next;
    logic [7:0]     event_next;
    logic [QIW-1:0] head_inc;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    // result register frees up whenever the downstream side takes its word
    assign s_ready = ~m_valid_reg | m_ready;
    assign in_fire = s_valid & s_ready;
    assign is_pop  = (s_kind == gbrc_pkg::KIND_POP);

    // pass-through when neither remap nor chords are in use
    assign bypass = ~remap_enable_reg & (chord_count_reg == '0);

    // raw button decode from the three report bytes
    always_comb begin
        logic [3:0] dirs;
        logic [7:0] src;
        btn_raw = '0;
        for (int i = 0; i < NB; i++) begin
            case (gbrc_pkg::BTN_SEL[i])
                gbrc_pkg::SEL_FACE:     src = s_dpad_face_byte;
                gbrc_pkg::SEL_SHOULDER: src = s_shoulder_byte;
                gbrc_pkg::SEL_SYSTEM:   src = s_system_byte;
                default:                src = 8'h00;
            endcase
            btn_raw[i] = |(src & gbrc_pkg::BTN_MASK[i]);
        end
        // hat nibble above eight reads as neutral
        dirs = gbrc_pkg::hat_to_dirs(s_dpad_face_byte[3:0]);
        btn_raw[gbrc_pkg::IDX_UP]    = dirs[0];
        btn_raw[gbrc_pkg::IDX_RIGHT] = dirs[1];
        btn_raw[gbrc_pkg::IDX_DOWN]  = dirs[2];
        btn_raw[gbrc_pkg::IDX_LEFT]  = dirs[3];
    end

    // chord scan, bindings in order; each may push one event
    always_comb begin
        logic [BW-1:0]  bind_w;
        logic [7:0]     ev;
        logic [2:0]     starter;
        logic [4:0]     bidx;
        logic [NB-1:0]  bbit;
        logic           held;
        logic [QCW:0]   slot;
        logic [QCW-1:0] cnt;
        logic [NB-1:0]  cons;
        logic [QCW-1:0] n_active;
        cons = consumed_reg & btn_raw;
        cnt  = count_reg;
        // counts above the chord limit saturate
        if (chord_count_reg > NC[gbrc_pkg::CHORD_CNT_W-1:0]) begin
            n_active = NC[QCW-1:0];
        end else begin
            n_active = QCW'(chord_count_reg);
        end
        for (int k = 0; k < NC; k++) begin
            if (k < 4) begin
                bind_w = bindings_low_reg[BW*(k%4) +: BW];
            end else begin
                bind_w = bindings_high_reg[BW*(k%4) +: BW];
            end
            ev      = bind_w[15:8];
            starter = bind_w[7:5];
            bidx    = bind_w[4:0];
            bbit    = '0;
            for (int j = 0; j < NB; j++) begin
                bbit[j] = (bidx == j[4:0]);
            end
            case (starter)
                gbrc_pkg::STARTER_PS:   held = btn_raw[gbrc_pkg::IDX_PS];
                gbrc_pkg::STARTER_LFN:  held = btn_raw[gbrc_pkg::IDX_LFN];
                gbrc_pkg::STARTER_RFN:  held = btn_raw[gbrc_pkg::IDX_RFN];
                gbrc_pkg::STARTER_MUTE: held = |(s_system_byte & gbrc_pkg::MUTE_MASK);
                default:                held = 1'b0;
            endcase
            // wrap of head plus fill, which stays below twice the depth
            slot = {1'b0, QCW'(head_reg)} + {1'b0, cnt};
            if (slot >= QD[QCW:0]) begin
                slot = slot - QD[QCW:0];
            end
            wr_addr[k] = slot[QIW-1:0];
            wr_data[k] = ev;
            wr_en[k]   = 1'b0;
            if ((k < n_active) && (ev != 8'h00) && held) begin
                if (|(btn_raw & bbit & ~prev_buttons_reg & ~cons)
                        && (cnt < QD[QCW-1:0])) begin
                    wr_en[k] = 1'b1;
                    cnt      = cnt + 1'b1;
                end
                cons = cons | (btn_raw & bbit);
            end
        end
        consumed_next    = cons;
        count_after_push = cnt;
        btn_vis          = btn_raw & ~cons;
    end

    // remap targets per source
    always_comb begin
        logic [44:0] hi_shift;
        for (int i = 0; i < NB; i++) begin
            hi_shift = '0;
            if (i < gbrc_pkg::LOW_SOURCES) begin
                tgt[i] = targets_low_reg[TW*i +: TW];
            end else if (TW * (i - gbrc_pkg::LOW_SOURCES) > 40) begin
                tgt[i] = '1;
            end else begin
                hi_shift = targets_high_reg >> (TW * (i - gbrc_pkg::LOW_SOURCES));
                tgt[i]   = hi_shift[TW-1:0];
            end
        end
    end

    // remap and trigger maxima
    always_comb begin
        logic       dig_l;
        logic       dig_r;
        logic [7:0] l_a;
        logic [7:0] l_b;
        logic [7:0] r_a;
        logic [7:0] r_b;
        logic [NB-1:0] rm;
        rm    = '0;
        dig_l = 1'b0;
        dig_r = 1'b0;
        for (int i = 0; i < NB; i++) begin
            for (int j = 0; j < NB; j++) begin
                if (btn_vis[i] && (tgt[i] == j[TW-1:0])) begin
                    rm[j] = 1'b1;
                end
            end
            if ((i != gbrc_pkg::IDX_L2) && (i != gbrc_pkg::IDX_R2) && btn_vis[i]) begin
                if (tgt[i] == gbrc_pkg::IDX_L2[TW-1:0]) dig_l = 1'b1;
                if (tgt[i] == gbrc_pkg::IDX_R2[TW-1:0]) dig_r = 1'b1;
            end
        end
        // left output: own level when L2 stays put, right level when R2 lands here
        l_a = (tgt[gbrc_pkg::IDX_L2] == gbrc_pkg::IDX_L2[TW-1:0]) ? s_left_trigger_level : 8'h00;
        l_b = (btn_vis[gbrc_pkg::IDX_R2] && (tgt[gbrc_pkg::IDX_R2] == gbrc_pkg::IDX_L2[TW-1:0]))
              ? s_right_trigger_level : 8'h00;
        r_a = (tgt[gbrc_pkg::IDX_R2] == gbrc_pkg::IDX_R2[TW-1:0]) ? s_right_trigger_level : 8'h00;
        r_b = (btn_vis[gbrc_pkg::IDX_L2] && (tgt[gbrc_pkg::IDX_L2] == gbrc_pkg::IDX_R2[TW-1:0]))
              ? s_left_trigger_level : 8'h00;
        if (remap_enable_reg) begin
            btn_out    = rm;
            left_next  = dig_l ? gbrc_pkg::TRIG_FULL : ((l_a > l_b) ? l_a : l_b);
            right_next = dig_r ? gbrc_pkg::TRIG_FULL : ((r_a > r_b) ? r_a : r_b);
        end else begin
            btn_out    = btn_vis;
            left_next  = s_left_trigger_level;
            right_next = s_right_trigger_level;
        end
    end

    // repack buttons into the report bytes
    always_comb begin
        logic [3:0] dirs;
        logic [7:0] o8;
        logic [7:0] o9;
        logic [7:0] o10;
        dirs = {btn_out[gbrc_pkg::IDX_LEFT], btn_out[gbrc_pkg::IDX_DOWN],
                btn_out[gbrc_pkg::IDX_RIGHT], btn_out[gbrc_pkg::IDX_UP]};
        o8  = {4'h0, gbrc_pkg::dirs_to_hat(dirs)};
        o9  = 8'h00;
        o10 = s_system_byte & gbrc_pkg::SYS_KEEP_MASK;
        for (int i = 0; i < NB; i++) begin
            if (btn_out[i]) begin
                case (gbrc_pkg::BTN_SEL[i])
                    gbrc_pkg::SEL_FACE:     o8  = o8 | gbrc_pkg::BTN_MASK[i];
                    gbrc_pkg::SEL_SHOULDER: o9  = o9 | gbrc_pkg::BTN_MASK[i];
                    gbrc_pkg::SEL_SYSTEM:   o10 = o10 | gbrc_pkg::BTN_MASK[i];
                    default:                o8  = o8;
                endcase
            end
        end
        if (bypass) begin
            face_next     = s_dpad_face_byte;
            shoulder_next = s_shoulder_byte;
            system_next   = s_system_byte;
        end else begin
            face_next     = o8;
            shoulder_next = o9;
            system_next   = o10;
        end
    end

    // pop side: oldest entry and next read pointer
    always_comb begin
        event_next = (count_reg != '0) ? queue_mem[head_reg] : 8'h00;
        if (head_reg == QIW'(QD - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = head_reg + 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remap_enable_reg  <= 1'b0;
            targets_low_reg   <= '0;
            targets_high_reg  <= '0;
            bindings_low_reg  <= '0;
            bindings_high_reg <= '0;
            chord_count_reg   <= '0;
        end else if (cfg_fire) begin
            case (cfg_index)
                gbrc_pkg::CFG_REMAP_ENABLE:  remap_enable_reg  <= cfg_data[0];
                gbrc_pkg::CFG_TARGETS_LOW:   targets_low_reg   <= cfg_data[59:0];
                gbrc_pkg::CFG_TARGETS_HIGH:  targets_high_reg  <= cfg_data[44:0];
                gbrc_pkg::CFG_BINDINGS_LOW:  bindings_low_reg  <= cfg_data;
                gbrc_pkg::CFG_BINDINGS_HIGH: bindings_high_reg <= cfg_data;
                gbrc_pkg::CFG_CHORD_COUNT:
                    chord_count_reg <= cfg_data[gbrc_pkg::CHORD_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // button history and queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_buttons_reg <= '0;
            consumed_reg     <= '0;
            head_reg         <= '0;
            count_reg        <= '0;
        end else if (cfg_fire && (cfg_index == gbrc_pkg::CFG_CHORD_COUNT)) begin
            // chord count write empties the queue
            head_reg  <= '0;
            count_reg <= '0;
        end else if (in_fire) begin
            if (is_pop) begin
                if (count_reg != '0) begin
                    head_reg  <= head_inc;
                    count_reg <= count_reg - 1'b1;
                end
            end else if (!bypass) begin
                prev_buttons_reg <= btn_raw;
                consumed_reg     <= consumed_next;
                count_reg        <= count_after_push;
            end
        end
    end

    // queue entries, written by the chords that fire this word
    always_ff @(posedge aclk) begin
        if (in_fire && !is_pop && !bypass) begin
            for (int k = 0; k < NC; k++) begin
                if (wr_en[k]) begin
                    queue_mem[wr_addr[k]] <= wr_data[k];
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            if (is_pop) begin
                o_face_reg     <= 8'h00;
                o_shoulder_reg <= 8'h00;
                o_system_reg   <= 8'h00;
                o_left_reg     <= 8'h00;
                o_right_reg    <= 8'h00;
                o_event_reg    <= event_next;
            end else begin
                o_face_reg     <= face_next;
                o_shoulder_reg <= shoulder_next;
                o_system_reg   <= system_next;
                o_left_reg     <= left_next;
                o_right_reg    <= right_next;
                o_event_reg    <= 8'h00;
            end
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_out_dpad_face_byte = o_face_reg;
    assign m_out_shoulder_byte  = o_shoulder_reg;
    assign m_out_system_byte    = o_system_reg;
    assign m_out_left_trigger   = o_left_reg;
    assign m_out_right_trigger  = o_right_reg;
    assign m_event_code         = o_event_reg;

    // fill count never passes the queue depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QD[QCW-1:0])
        else $error("event queue fill count above depth");

    // a pop on an empty queue returns a zero event
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && is_pop && (count_reg == '0)) |=> (m_valid && (m_event_code == 8'h00)))
        else $error("pop of empty queue returned an event");

    // report words never carry an event code
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !is_pop) |=> (m_event_code == 8'h00))
        else $error("report word carries an event code");

    // pass-through leaves the button history alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !is_pop && bypass && !cfg_fire)
            |=> ($stable(prev_buttons_reg) && $stable(consumed_reg) && $stable(count_reg)))
        else $error("pass-through word changed chord state");

endmodule
